// ----- rtl/core/leir_pkg.sv -----
package leir_pkg;

  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_NL     = 8'h0A;
  localparam logic [7:0] KEY_NUL    = 8'h00;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_CHAR  = 2'd1,
    ECHO_ERASE = 2'd2
  } echo_kind_t;

  typedef enum logic [1:0] {
    RD_OK    = 2'd0,
    RD_EMPTY = 2'd1,
    RD_EOF   = 2'd2
  } rd_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_KILL,
    S_KILL_ADDR
  } seq_state_t;

  typedef struct packed {
    echo_kind_t echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_committed;
    logic       dump_request;
    rd_status_t read_status;
    logic [7:0] read_byte;
  } result_t;

endpackage

// ----- rtl/core/leir_store.sv -----
module leir_store #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] waddr,
  input  logic [7:0]                      wdata,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] raddr,
  output logic [7:0]                      rdata
);

  logic [7:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/leir_step.sv -----
module leir_step #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic [$clog2(BUFFER_DEPTH):0] ptr_i,
  input  logic                          down,
  output logic [$clog2(BUFFER_DEPTH):0] ptr_o
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(BUFFER_DEPTH - 1);

  logic          lap;
  logic [AW-1:0] slot;

  assign lap  = ptr_i[AW];
  assign slot = ptr_i[AW-1:0];

  // Pointer is {lap, slot}; slot wraps at the depth and flips the lap bit
  always_comb begin
    if (down) begin
      if (slot == '0) begin
        ptr_o = {~lap, LAST};
      end else begin
        ptr_o = {lap, slot - AW'(1)};
      end
    end else begin
      if (slot == LAST) begin
        ptr_o = {~lap, {AW{1'b0}}};
      end else begin
        ptr_o = {lap, slot + AW'(1)};
      end
    end
  end

endmodule

// ----- rtl/core/leir_seq.sv -----
module leir_seq #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [7:0]                      in_key_char,
  input  logic                            in_first_of_read,
  output logic                            mem_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                      mem_wdata,
  output logic [$clog2(BUFFER_DEPTH)-1:0] mem_raddr,
  input  logic [7:0]                      mem_rdata,
  output logic                            done,
  output leir_pkg::result_t               result
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = AW + 1;

  leir_pkg::seq_state_t state_r, state_nxt;

  logic          kind_r;
  logic [7:0]    key_r;
  logic          first_r;
  logic [PW-1:0] read_ptr_r, read_ptr_nxt;
  logic [PW-1:0] commit_ptr_r, commit_ptr_nxt;
  logic [PW-1:0] edit_ptr_r, edit_ptr_nxt;
  logic [7:0]    erase_n_r, erase_n_nxt;

  logic [PW-1:0] step_ptr;
  logic          step_down;
  logic [PW-1:0] step_res;
  logic [7:0]    key_c;

  function automatic logic ring_full(logic [PW-1:0] e, logic [PW-1:0] r);
    return (e[AW-1:0] == r[AW-1:0]) && (e[AW] != r[AW]);
  endfunction

  leir_step #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_step (
    .ptr_i(step_ptr),
    .down (step_down),
    .ptr_o(step_res)
  );

  assign busy  = (state_r != leir_pkg::S_IDLE);
  assign key_c = (key_r == leir_pkg::KEY_CR) ? leir_pkg::KEY_NL : key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= leir_pkg::S_IDLE;
      read_ptr_r   <= '0;
      commit_ptr_r <= '0;
      edit_ptr_r   <= '0;
      erase_n_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      read_ptr_r   <= read_ptr_nxt;
      commit_ptr_r <= commit_ptr_nxt;
      edit_ptr_r   <= edit_ptr_nxt;
      erase_n_r    <= erase_n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r  <= in_kind;
      key_r   <= in_key_char;
      first_r <= in_first_of_read;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    read_ptr_nxt   = read_ptr_r;
    commit_ptr_nxt = commit_ptr_r;
    edit_ptr_nxt   = edit_ptr_r;
    erase_n_nxt    = erase_n_r;
    mem_we         = 1'b0;
    mem_waddr      = edit_ptr_r[AW-1:0];
    mem_wdata      = key_c;
    mem_raddr      = read_ptr_r[AW-1:0];
    step_ptr       = edit_ptr_r;
    step_down      = 1'b1;
    done           = 1'b0;
    result.echo_kind      = leir_pkg::ECHO_NONE;
    result.echo_char      = 8'd0;
    result.erase_count    = 8'd0;
    result.line_committed = 1'b0;
    result.dump_request   = 1'b0;
    result.read_status    = leir_pkg::RD_OK;
    result.read_byte      = 8'd0;

    case (state_r)
      leir_pkg::S_IDLE: begin
        // Read slot is presented here so the byte is ready in decode
        if (start) begin
          erase_n_nxt = 8'd0;
          state_nxt   = leir_pkg::S_DECODE;
        end
      end

      leir_pkg::S_DECODE: begin
        state_nxt = leir_pkg::S_IDLE;
        done      = 1'b1;
        if (kind_r) begin
          step_ptr  = read_ptr_r;
          step_down = 1'b0;
          if (read_ptr_r == commit_ptr_r) begin
            result.read_status = leir_pkg::RD_EMPTY;
          end else if (mem_rdata == leir_pkg::KEY_CTRL_D) begin
            result.read_status = leir_pkg::RD_EOF;
            if (first_r) begin
              read_ptr_nxt = step_res;
            end
          end else begin
            read_ptr_nxt     = step_res;
            result.read_byte = mem_rdata;
          end
        end else if (key_r == leir_pkg::KEY_CTRL_P) begin
          result.dump_request = 1'b1;
        end else if (key_r == leir_pkg::KEY_CTRL_U) begin
          if (edit_ptr_r != commit_ptr_r) begin
            // Fetch the character before the edit point and start the walk
            mem_raddr = step_res[AW-1:0];
            done      = 1'b0;
            state_nxt = leir_pkg::S_KILL;
          end
        end else if (key_r inside {leir_pkg::KEY_CTRL_H, leir_pkg::KEY_DEL}) begin
          if (edit_ptr_r != commit_ptr_r) begin
            edit_ptr_nxt       = step_res;
            result.echo_kind   = leir_pkg::ECHO_ERASE;
            result.erase_count = 8'd1;
          end
        end else if (key_r != leir_pkg::KEY_NUL && !ring_full(edit_ptr_r, read_ptr_r)) begin
          step_down        = 1'b0;
          mem_we           = 1'b1;
          edit_ptr_nxt     = step_res;
          result.echo_kind = leir_pkg::ECHO_CHAR;
          result.echo_char = key_c;
          if (key_c == leir_pkg::KEY_NL || key_c == leir_pkg::KEY_CTRL_D ||
              ring_full(step_res, read_ptr_r)) begin
            commit_ptr_nxt        = step_res;
            result.line_committed = 1'b1;
          end
        end
      end

      leir_pkg::S_KILL: begin
        if (mem_rdata == leir_pkg::KEY_NL) begin
          done      = 1'b1;
          state_nxt = leir_pkg::S_IDLE;
          result.echo_kind   = (erase_n_r != 8'd0) ? leir_pkg::ECHO_ERASE
                                                   : leir_pkg::ECHO_NONE;
          result.erase_count = erase_n_r;
        end else begin
          // Drop one character; count saturates
          edit_ptr_nxt = step_res;
          erase_n_nxt  = (erase_n_r == 8'hFF) ? erase_n_r : erase_n_r + 8'd1;
          state_nxt    = leir_pkg::S_KILL_ADDR;
        end
      end

      leir_pkg::S_KILL_ADDR: begin
        if (edit_ptr_r == commit_ptr_r) begin
          done      = 1'b1;
          state_nxt = leir_pkg::S_IDLE;
          result.echo_kind   = (erase_n_r != 8'd0) ? leir_pkg::ECHO_ERASE
                                                   : leir_pkg::ECHO_NONE;
          result.erase_count = erase_n_r;
        end else begin
          mem_raddr = step_res[AW-1:0];
          state_nxt = leir_pkg::S_KILL;
        end
      end

      default: begin
        state_nxt = leir_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/line_edit_input_ring.sv -----
// Console line discipline over a ring of BUFFER_DEPTH bytes. Pulse start while
// busy is low to hand in one word: a keystroke (in_kind 0) or a one-byte read
// (in_kind 1). Exactly one result word follows, shown for a single cycle with
// out_strobe high; it cannot be held off, so capture it when the strobe is
// seen. A read, a plain keystroke, backspace or ctrl-P holds busy high only
// through the decode state and the strobe comes the cycle after, so a new
// word can be taken while that strobe is shown. Ctrl-U walks back through
// the ring one character per pass through the kill and kill-address states
// on the single pointer step unit and the single read port of the line
// memory. An open line never fills the ring.
module line_edit_input_ring #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_kind,
  input  logic [7:0] in_key_char,
  input  logic       in_first_of_read,
  output logic       out_strobe,
  output logic [1:0] out_echo_kind,
  output logic [7:0] out_echo_char,
  output logic [7:0] out_erase_count,
  output logic       out_line_committed,
  output logic       out_dump_request,
  output logic [1:0] out_read_status,
  output logic [7:0] out_read_byte
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        mem_rdata;
  logic              done;
  leir_pkg::result_t result;
  leir_pkg::result_t result_r;
  logic              out_strobe_r;

  leir_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_key_char     (in_key_char),
    .in_first_of_read(in_first_of_read),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .done            (done),
    .result          (result)
  );

  leir_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result_r <= result;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_echo_kind      = result_r.echo_kind;
  assign out_echo_char      = result_r.echo_char;
  assign out_erase_count    = result_r.erase_count;
  assign out_line_committed = result_r.line_committed;
  assign out_dump_request   = result_r.dump_request;
  assign out_read_status    = result_r.read_status;
  assign out_read_byte      = result_r.read_byte;

endmodule

// ----- rtl/core/leir_checker.sv -----
module leir_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [1:0] out_echo_kind,
  input logic [7:0] out_erase_count,
  input logic [1:0] out_read_status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted word");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_read_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_read_status != leir_pkg::RD_OK) |->
      (out_echo_kind == leir_pkg::ECHO_NONE))
    else $error("echo on a read result");

  a_erase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_echo_kind == leir_pkg::ECHO_ERASE) |-> (out_erase_count != 8'd0))
    else $error("erase echo with zero count");

endmodule

bind line_edit_input_ring leir_checker u_leir_checker (.*);
